FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file fpt_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with reset disable
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Clocked next-cycle implication with reset disable
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/core/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared constants for the Fermat primality tester.
// ----------------------------------------------------------------------------
package fpt_pkg;
   localparam int DEF_WIDTH   = 32;
   localparam int CAND_W      = 32;
   localparam int ROUNDS_W    = 8;
   localparam int LFSR_W      = 31;
   localparam int CSR_DATA_W  = 31;
   localparam int CSR_ADDR_W  = 1;
   localparam int REASON_W    = 2;

   localparam logic [CSR_ADDR_W-1:0] REG_ROUNDS = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SEED   = 1'd1;

   localparam logic [REASON_W-1:0] RSN_PASS   = 2'd0;
   localparam logic [REASON_W-1:0] RSN_SMALL  = 2'd1;
   localparam logic [REASON_W-1:0] RSN_FACTOR = 2'd2;
   localparam logic [REASON_W-1:0] RSN_FERMAT = 2'd3;

   localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 8'd3;
   localparam logic [LFSR_W-1:0]   LFSR_RESET   = 31'd1;
endpackage

FILE: rtl/core/fermat_primality_tester.sv
// ----------------------------------------------------------------------------
// fermat_primality_tester
// Fermat probable-prime test over a shared add/compare/subtract unit.
// ----------------------------------------------------------------------------
// Flow: candidates 0..4 go straight to S_DONE, which then raises rsp_valid; otherwise
// each round reduces an LFSR value mod (n-4) to pick the base, runs Euclid (with a
// bit-serial remainder per step) and a modular exponentiation (a double-and-add
// square per exponent bit, plus a double-and-add multiply where the bit is set).
// Throughput: one candidate at a time; the next transfer waits for the result's.
// Reset: synchronous, active high; rounds=3, LFSR=1, block idle.
module fermat_primality_tester
#(
   parameter int WIDTH = fpt_pkg::DEF_WIDTH
)(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fpt_pkg::CAND_W-1:0]       req_candidate,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_probably_prime,
   output logic [fpt_pkg::REASON_W-1:0]     rsp_verdict_reason,
   input  logic                             csr_write,
   input  logic [fpt_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [fpt_pkg::CSR_DATA_W-1:0]   csr_data
);
   import fpt_pkg::*;

   localparam int DW = (WIDTH > LFSR_W) ? WIDTH : LFSR_W;
   localparam int CW = $clog2(DW + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ROUND  = 4'd1;
   localparam logic [3:0] S_RED    = 4'd2;
   localparam logic [3:0] S_GCDCHK = 4'd3;
   localparam logic [3:0] S_GCDMOD = 4'd4;
   localparam logic [3:0] S_PWSTEP = 4'd5;
   localparam logic [3:0] S_MUL    = 4'd6;
   localparam logic [3:0] S_PWNEXT = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [ROUNDS_W-1:0] rounds_ff, rounds_in;
   logic [LFSR_W-1:0]   lfsr_ff, lfsr_in;
   logic [ROUNDS_W-1:0] left_ff, left_in;
   logic [WIDTH-1:0]    n_ff, n_in;
   logic [WIDTH-1:0]    a_ff, a_in;
   logic [WIDTH-1:0]    gx_ff, gx_in, gy_ff, gy_in;
   logic [WIDTH-1:0]    rem_ff, rem_in, div_ff, div_in;
   logic [DW-1:0]       dvd_ff, dvd_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                gcd_ph_ff, gcd_ph_in;
   logic [WIDTH-1:0]    res_ff, res_in, bas_ff, bas_in, exp_ff, exp_in;
   logic [WIDTH-1:0]    mx_ff, mx_in, my_ff, my_in, acc_ff, acc_in;
   logic                msq_ff, msq_in;
   logic                rv_ff, rv_in, pp_ff, pp_in;
   logic [REASON_W-1:0] rs_ff, rs_in;

   // shared modular adder: (x + y) mod m, x,y < m
   logic [WIDTH-1:0] ax, ay, am, asum;
   logic [WIDTH-1:0] gap;
   always_comb begin
      gap  = am - ay;
      asum = (ax >= gap) ? (ax - gap) : (ax + ay);
   end

   logic [WIDTH-1:0] cand_w;
   logic [WIDTH:0]   shl;
   logic [LFSR_W-1:0] lfsr_nx;
   assign cand_w  = WIDTH'(req_candidate);
   assign lfsr_nx = {lfsr_ff[LFSR_W-2:0], lfsr_ff[30] ^ lfsr_ff[27]};

   assign req_ready          = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid          = rv_ff;
   assign rsp_probably_prime = pp_ff;
   assign rsp_verdict_reason = rs_ff;

   always_comb begin
      state_in = state_ff; rounds_in = rounds_ff; lfsr_in = lfsr_ff;
      left_in = left_ff; n_in = n_ff; a_in = a_ff; gx_in = gx_ff; gy_in = gy_ff;
      rem_in = rem_ff; dvd_in = dvd_ff; div_in = div_ff; cnt_in = cnt_ff;
      gcd_ph_in = gcd_ph_ff; res_in = res_ff; bas_in = bas_ff; exp_in = exp_ff;
      mx_in = mx_ff; my_in = my_ff; acc_in = acc_ff; msq_in = msq_ff;
      rv_in = rv_ff; pp_in = pp_ff; rs_in = rs_ff;
      ax = acc_ff; ay = mx_ff; am = n_ff;
      shl = '0;

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      if (csr_write) begin
         unique case (csr_index)
            REG_ROUNDS: rounds_in = csr_data[ROUNDS_W-1:0];
            REG_SEED:   lfsr_in = (csr_data == '0) ? LFSR_RESET : csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               n_in = cand_w; left_in = rounds_ff;
               if (cand_w <= WIDTH'(1) || cand_w == WIDTH'(4)) begin
                  pp_in = 1'b0; rs_in = RSN_SMALL; state_in = S_DONE;
               end else if (cand_w <= WIDTH'(3)) begin
                  pp_in = 1'b1; rs_in = RSN_PASS; state_in = S_DONE;
               end else begin
                  state_in = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            if (left_ff == '0) begin
               pp_in = 1'b1; rs_in = RSN_PASS; state_in = S_DONE;
            end else begin
               lfsr_in = lfsr_nx;
               // reduce r mod (n-4) one bit per cycle
               dvd_in = DW'(lfsr_nx); div_in = n_ff - WIDTH'(4);
               rem_in = '0; cnt_in = CW'(DW);
               gcd_ph_in = 1'b0; state_in = S_RED;
            end
         end
         S_RED, S_GCDMOD: begin
            if (cnt_ff == '0) begin
               if (state_ff == S_RED) begin
                  a_in = rem_ff + WIDTH'(2);
                  gx_in = n_ff; gy_in = rem_ff + WIDTH'(2);
                  state_in = S_GCDCHK;
               end else begin
                  gx_in = gy_ff; gy_in = rem_ff; state_in = S_GCDCHK;
               end
            end else begin
               shl = {rem_ff, dvd_ff[DW-1]};
               if (shl >= {1'b0, div_ff}) shl = shl - {1'b0, div_ff};
               rem_in = shl[WIDTH-1:0];
               dvd_in = {dvd_ff[DW-2:0], 1'b0};
               cnt_in = cnt_ff - CW'(1);
            end
         end
         S_GCDCHK: begin
            if (gy_ff == '0) begin
               if (gx_ff != WIDTH'(1)) begin
                  pp_in = 1'b0; rs_in = RSN_FACTOR; state_in = S_DONE;
               end else begin
                  res_in = WIDTH'(1); bas_in = a_ff; exp_in = n_ff - WIDTH'(1);
                  state_in = S_PWSTEP;
               end
            end else begin
               dvd_in = DW'(gx_ff); div_in = gy_ff; rem_in = '0;
               cnt_in = CW'(DW); state_in = S_GCDMOD;
            end
         end
         S_PWSTEP: begin
            if (exp_ff == '0) begin
               if (res_ff != WIDTH'(1)) begin
                  pp_in = 1'b0; rs_in = RSN_FERMAT; state_in = S_DONE;
               end else begin
                  left_in = left_ff - ROUNDS_W'(1); state_in = S_ROUND;
               end
            end else begin
               msq_in = !exp_ff[0];
               mx_in = exp_ff[0] ? bas_ff : bas_ff;
               my_in = exp_ff[0] ? res_ff : bas_ff;
               acc_in = '0; state_in = S_MUL;
            end
         end
         S_MUL: begin
            // double-and-add: my is the multiplier, mx the doubling term
            if (my_ff == '0) begin
               if (!msq_ff) begin
                  res_in = acc_ff; msq_in = 1'b1;
                  mx_in = bas_ff; my_in = bas_ff; acc_in = '0;
               end else begin
                  bas_in = acc_ff; state_in = S_PWNEXT;
               end
            end else if (my_ff[0] && !gcd_ph_ff) begin
               ax = acc_ff; ay = mx_ff; acc_in = asum; gcd_ph_in = 1'b1;
            end else begin
               ax = mx_ff; ay = mx_ff; mx_in = asum;
               my_in = my_ff >> 1; gcd_ph_in = 1'b0;
            end
         end
         S_PWNEXT: begin
            exp_in = exp_ff >> 1; state_in = S_PWSTEP;
         end
         S_DONE: begin
            if (!rv_ff) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rounds_ff <= ROUNDS_RESET; lfsr_ff <= LFSR_RESET;
         rv_ff <= 1'b0; gcd_ph_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rounds_ff <= rounds_in; lfsr_ff <= lfsr_in;
         rv_ff <= rv_in; gcd_ph_ff <= gcd_ph_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in; n_ff <= n_in; a_ff <= a_in; gx_ff <= gx_in;
      gy_ff <= gy_in; rem_ff <= rem_in; dvd_ff <= dvd_in; div_ff <= div_in;
      cnt_ff <= cnt_in; res_ff <= res_in; bas_ff <= bas_in; exp_ff <= exp_in;
      mx_ff <= mx_in; my_ff <= my_in; acc_ff <= acc_in; msq_ff <= msq_in;
      pp_ff <= pp_in; rs_ff <= rs_in;
   end
endmodule

FILE: rtl/core/fpt_checker.sv
// ----------------------------------------------------------------------------
// fpt_checker
// Port-level checks for the Fermat primality tester.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fpt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_probably_prime,
   input logic [1:0] rsp_verdict_reason
);
   import fpt_pkg::*;

   `ASSERT_IMPL(a_no_ready_busy, clock, reset, rsp_valid, !req_ready, "ready while result held")
   `ASSERT_IMPL(a_prime_reason, clock, reset, rsp_valid && rsp_probably_prime, rsp_verdict_reason == RSN_PASS, "prime with fail reason")
   `ASSERT_IMPL(a_comp_reason, clock, reset, rsp_valid && !rsp_probably_prime, rsp_verdict_reason != RSN_PASS, "composite with pass reason")
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready, "ready right after transfer")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_verdict_reason), "result dropped")
endmodule

bind fermat_primality_tester fpt_checker u_fpt_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_probably_prime(rsp_probably_prime), .rsp_verdict_reason(rsp_verdict_reason)
);
